// ===== rtl/lbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbl_pkg
// Shared types, token codes and keyword table for the BASIC line lexer.
// ----------------------------------------------------------------------------
package lbl_pkg;

  localparam int KW_CHARS  = 6;
  localparam int KW_COUNT  = 24;
  localparam logic [7:0] POS_CAP = 8'd255;
  localparam logic [30:0] INT_CAP = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    M_IDLE, M_STRING, M_NUMBER, M_WORD, M_DOT, M_LT, M_GT
  } lbl_mode_t;

  localparam logic [5:0] K_END      = 6'd0;
  localparam logic [5:0] K_NUMBER   = 6'd1;
  localparam logic [5:0] K_STRING   = 6'd2;
  localparam logic [5:0] K_IDENT    = 6'd3;
  localparam logic [5:0] K_KEYWORD0 = 6'd4;
  localparam logic [5:0] K_PLUS     = 6'd28;
  localparam logic [5:0] K_MINUS    = 6'd29;
  localparam logic [5:0] K_STAR     = 6'd30;
  localparam logic [5:0] K_SLASH    = 6'd31;
  localparam logic [5:0] K_CARET    = 6'd32;
  localparam logic [5:0] K_LPAREN   = 6'd33;
  localparam logic [5:0] K_RPAREN   = 6'd34;
  localparam logic [5:0] K_COMMA    = 6'd35;
  localparam logic [5:0] K_SEMI     = 6'd36;
  localparam logic [5:0] K_COLON    = 6'd37;
  localparam logic [5:0] K_EQ       = 6'd38;
  localparam logic [5:0] K_NE       = 6'd39;
  localparam logic [5:0] K_LT       = 6'd40;
  localparam logic [5:0] K_LE       = 6'd41;
  localparam logic [5:0] K_GE       = 6'd42;
  localparam logic [5:0] K_GT       = 6'd43;

  typedef struct packed {
    logic [5:0]  kind;
    logic        has_dot;
    logic [30:0] int_value;
    logic [7:0]  text_start;
    logic [7:0]  text_length;
    logic [7:0]  token_total;
    logic        last;
  } tok_t;

  // Keyword text, first character in the top byte, zero padded.
  localparam logic [47:0] KW_NAME [KW_COUNT] = '{
    {"PRINT", 8'h0}, {"LET", 24'h0}, {"IF", 32'h0}, {"THEN", 16'h0},
    {"ELSE", 16'h0}, {"FOR", 24'h0}, {"TO", 32'h0}, {"STEP", 16'h0},
    {"NEXT", 16'h0}, {"GOTO", 16'h0}, {"GOSUB", 8'h0}, "RETURN",
    {"INPUT", 8'h0}, {"REM", 24'h0}, {"CLS", 24'h0}, "LOCATE",
    {"COLOR", 8'h0}, {"END", 24'h0}, {"LIST", 16'h0}, {"RUN", 24'h0},
    {"NEW", 24'h0}, {"SAVE", 16'h0}, {"LOAD", 16'h0}, "SYSTEM"
  };
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{
    8'd5, 8'd3, 8'd2, 8'd4, 8'd4, 8'd3, 8'd2, 8'd4, 8'd4, 8'd4, 8'd5, 8'd6,
    8'd5, 8'd3, 8'd3, 8'd6, 8'd5, 8'd3, 8'd4, 8'd3, 8'd3, 8'd4, 8'd4, 8'd6
  };

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [7:0] start,
                                  input logic [7:0] len);
    tok_t t;
    t = '0;
    t.kind        = kind;
    t.text_start  = start;
    t.text_length = len;
    return t;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v < POS_CAP) ? v + 8'd1 : v;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) ? c - 8'd32 : c;
  endfunction

  // Parallel compare of the held word against every keyword.
  function automatic logic [5:0] kw_kind(input logic [47:0] word, input logic [7:0] len);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (word == KW_NAME[i] && len == KW_LEN[i]) k = K_KEYWORD0 + 6'(i);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lbl_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbl_core
// Lexer state and per-character step; yields up to two tokens per request.
// ----------------------------------------------------------------------------
module lbl_core import lbl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] ch,
  input  wire logic       line_end,
  output tok_t            tok0,
  output tok_t            tok1,
  output logic            push0,
  output logic            push1
);

  lbl_mode_t   mode_r, mode_nxt;
  logic [47:0] word_r, word_nxt;
  logic [7:0]  wlen_r, wlen_nxt;
  logic [7:0]  tstart_r, tstart_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [30:0] accum_r, accum_nxt;
  logic        dot_r, dot_nxt;
  logic [7:0]  total_r, total_nxt;

  // Start-of-token decode for the current character.
  lbl_mode_t   sc_mode;
  logic        sc_v;
  tok_t        sc_tok;
  logic [7:0]  sc_tstart;
  logic        sc_setnum, sc_setword, sc_setstr;

  // Token that closes the pending one, and the one that follows it.
  logic        f_v, s_v, f_cnt, s_cnt;
  tok_t        f_tok, s_tok;
  logic        is_dig, is_alpha, is_wordc;
  logic [34:0] acc10;
  logic [7:0]  t_after_f;

  always_comb begin
    is_dig   = ch inside {[8'h30:8'h39]};
    is_alpha = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    is_wordc = is_alpha || is_dig || ch inside {8'h5F, 8'h24, 8'h25, 8'h21};
    acc10    = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0} + {31'd0, ch[3:0]};

    sc_mode    = M_IDLE;
    sc_v       = 1'b0;
    sc_tok     = mk_tok(K_PLUS, pos_r, 8'd1);
    sc_tstart  = pos_r;
    sc_setnum  = 1'b0;
    sc_setword = 1'b0;
    sc_setstr  = 1'b0;
    case (ch)
      8'h3F: begin sc_v = 1'b1; sc_tok.kind = K_KEYWORD0; end
      8'h22: begin sc_mode = M_STRING; sc_tstart = sat_inc(pos_r); sc_setstr = 1'b1; end
      8'h2E: sc_mode = M_DOT;
      8'h3C: sc_mode = M_LT;
      8'h3E: sc_mode = M_GT;
      8'h2B: begin sc_v = 1'b1; sc_tok.kind = K_PLUS;   end
      8'h2D: begin sc_v = 1'b1; sc_tok.kind = K_MINUS;  end
      8'h2A: begin sc_v = 1'b1; sc_tok.kind = K_STAR;   end
      8'h2F: begin sc_v = 1'b1; sc_tok.kind = K_SLASH;  end
      8'h5E: begin sc_v = 1'b1; sc_tok.kind = K_CARET;  end
      8'h28: begin sc_v = 1'b1; sc_tok.kind = K_LPAREN; end
      8'h29: begin sc_v = 1'b1; sc_tok.kind = K_RPAREN; end
      8'h2C: begin sc_v = 1'b1; sc_tok.kind = K_COMMA;  end
      8'h3B: begin sc_v = 1'b1; sc_tok.kind = K_SEMI;   end
      8'h3A: begin sc_v = 1'b1; sc_tok.kind = K_COLON;  end
      8'h3D: begin sc_v = 1'b1; sc_tok.kind = K_EQ;     end
      default: begin
        if (is_dig) begin
          sc_mode = M_NUMBER; sc_setnum = 1'b1;
        end else if (is_alpha || ch == 8'h5F) begin
          sc_mode = M_WORD; sc_setword = 1'b1;
        end
      end
    endcase

    mode_nxt   = mode_r;
    word_nxt   = word_r;
    wlen_nxt   = wlen_r;
    tstart_nxt = tstart_r;
    pos_nxt    = sat_inc(pos_r);
    accum_nxt  = accum_r;
    dot_nxt    = dot_r;
    f_v   = 1'b0;
    f_tok = mk_tok(K_LT, tstart_r, 8'd1);
    s_v   = 1'b0;
    s_tok = sc_tok;
    // Whether the next state comes from the start-of-token decode.
    begin : step_decode
      logic restart;
      restart = 1'b0;
      if (line_end) begin
        case (mode_r)
          M_STRING: begin f_v = 1'b1; f_tok = mk_tok(K_STRING, tstart_r, wlen_r); end
          M_NUMBER: begin
            f_v = 1'b1; f_tok = mk_tok(K_NUMBER, tstart_r, wlen_r);
            f_tok.has_dot = dot_r; f_tok.int_value = dot_r ? '0 : accum_r;
          end
          M_WORD:   begin f_v = 1'b1; f_tok = mk_tok(kw_kind(word_r, wlen_r), tstart_r, wlen_r); end
          M_LT:     f_v = 1'b1;
          M_GT:     begin f_v = 1'b1; f_tok.kind = K_GT; end
          default:  f_v = 1'b0;
        endcase
      end else begin
        case (mode_r)
          M_STRING: begin
            if (ch == 8'h22) begin
              f_v = 1'b1; f_tok = mk_tok(K_STRING, tstart_r, wlen_r); mode_nxt = M_IDLE;
            end else wlen_nxt = sat_inc(wlen_r);
          end
          M_NUMBER: begin
            if (is_dig) begin
              accum_nxt = (acc10 > {4'd0, INT_CAP}) ? INT_CAP : acc10[30:0];
              wlen_nxt  = sat_inc(wlen_r);
            end else if (ch == 8'h2E) begin
              dot_nxt = 1'b1; wlen_nxt = sat_inc(wlen_r);
            end else begin
              f_v = 1'b1; f_tok = mk_tok(K_NUMBER, tstart_r, wlen_r);
              f_tok.has_dot = dot_r; f_tok.int_value = dot_r ? '0 : accum_r;
              restart = 1'b1;
            end
          end
          M_WORD: begin
            if (is_wordc) begin
              if (wlen_r < 8'(KW_CHARS)) word_nxt[47 - 8*wlen_r[2:0] -: 8] = upcase(ch);
              wlen_nxt = sat_inc(wlen_r);
            end else begin
              f_v = 1'b1; f_tok = mk_tok(kw_kind(word_r, wlen_r), tstart_r, wlen_r);
              restart = 1'b1;
            end
          end
          M_DOT: begin
            if (is_dig) begin
              mode_nxt = M_NUMBER; dot_nxt = 1'b1; accum_nxt = '0; wlen_nxt = 8'd2;
            end else restart = 1'b1;
          end
          M_LT: begin
            if (ch == 8'h3E || ch == 8'h3D) begin
              f_v = 1'b1; f_tok = mk_tok((ch == 8'h3E) ? K_NE : K_LE, tstart_r, 8'd2);
              mode_nxt = M_IDLE;
            end else begin f_v = 1'b1; restart = 1'b1; end
          end
          M_GT: begin
            f_v = 1'b1;
            if (ch == 8'h3D) begin
              f_tok = mk_tok(K_GE, tstart_r, 8'd2); mode_nxt = M_IDLE;
            end else begin f_tok.kind = K_GT; restart = 1'b1; end
          end
          default: restart = 1'b1;
        endcase
      end
      if (restart) begin
        s_v        = sc_v;
        mode_nxt   = sc_mode;
        tstart_nxt = sc_tstart;
        if (sc_setstr) wlen_nxt = 8'd0;
        if (sc_setnum) begin
          wlen_nxt = 8'd1; dot_nxt = 1'b0; accum_nxt = {27'd0, ch[3:0]};
        end
        if (sc_setword) begin
          wlen_nxt = 8'd1; word_nxt = {upcase(ch), 40'd0};
        end
      end
    end

    f_cnt     = f_v;
    t_after_f = (f_cnt && total_r != 8'd255) ? total_r + 8'd1 : total_r;
    if (line_end) begin
      s_v   = 1'b1;
      s_tok = '0;
      s_tok.token_total = t_after_f;
    end
    s_cnt     = s_v && !line_end;
    total_nxt = (s_cnt && t_after_f != 8'd255) ? t_after_f + 8'd1 : t_after_f;

    if (f_v) begin
      tok0 = f_tok; tok0.last = !s_v;
      tok1 = s_tok; tok1.last = 1'b1;
    end else begin
      tok0 = s_tok; tok0.last = 1'b1;
      tok1 = s_tok; tok1.last = 1'b1;
    end
    push0 = step && (f_v || s_v);
    push1 = step && f_v && s_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      word_r   <= '0;
      wlen_r   <= '0;
      tstart_r <= '0;
      pos_r    <= '0;
      accum_r  <= '0;
      dot_r    <= 1'b0;
      total_r  <= '0;
    end else if (step) begin
      if (line_end) begin
        // A line end returns every piece of line state to its reset value.
        mode_r   <= M_IDLE;
        word_r   <= '0;
        wlen_r   <= '0;
        tstart_r <= '0;
        pos_r    <= '0;
        accum_r  <= '0;
        dot_r    <= 1'b0;
        total_r  <= '0;
      end else begin
        mode_r   <= mode_nxt;
        word_r   <= word_nxt;
        wlen_r   <= wlen_nxt;
        tstart_r <= tstart_nxt;
        pos_r    <= pos_nxt;
        accum_r  <= accum_nxt;
        dot_r    <= dot_nxt;
        total_r  <= total_nxt;
      end
    end
  end

  a_two_needs_one: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0) else $error("second token pushed without first");
  a_end_single: assert property (@(posedge clk) disable iff (!rst_n)
    (step && line_end) |-> push0) else $error("line end produced no end token");
  a_pos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (step && line_end) |=> pos_r == 8'd0) else $error("position not cleared at line end");

endmodule
`default_nettype wire

// ===== rtl/lbl_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbl_outq
// Four-entry token queue: takes up to two tokens a cycle, delivers one when popped.
// ----------------------------------------------------------------------------
module lbl_outq import lbl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push0,
  input  wire logic push1,
  input  wire tok_t tok0,
  input  wire tok_t tok1,
  output logic      room2,
  output logic      q_valid,
  input  wire logic q_pop,
  output tok_t      q_tok
);

  tok_t       mem_r [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign q_valid = cnt_r != 3'd0;
  assign room2   = cnt_r <= 3'd2;
  assign q_tok   = mem_r[rd_r];
  assign pop     = q_valid && q_pop;

  always_comb begin
    wr_nxt  = wr_r + {1'b0, push0} + {1'b0, push1};
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {2'd0, push0} + {2'd0, push1} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push0) mem_r[wr_r] <= tok0;
    if (push1) mem_r[wr_r + 2'd1] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("token queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push0 |-> room2) else $error("push without room");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 3'd4) |-> (cnt_r[1:0] == (wr_r - rd_r))) else $error("queue count mismatch");

endmodule
`default_nettype wire

// ===== rtl/basic_line_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// basic_line_lexer
// Lexes a BASIC source line one character per request into tokens.
// ----------------------------------------------------------------------------
// One character or line-end request is taken per clock; each updates the lexer
// state and yields zero, one or two tokens, which enter a four-entry queue in
// front of the output. The output delivers one token per cycle while out_ready
// is high, so input is held off only while the queue has fewer than two free
// entries, for example after a run of two-token requests under output stall.
// Tokens are written into the queue on acceptance and leave it in order.
module basic_line_lexer import lbl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_line_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_token_kind,
  output logic             out_has_dot,
  output logic [30:0]      out_int_value,
  output logic [7:0]       out_text_start,
  output logic [7:0]       out_text_length,
  output logic [7:0]       out_token_total,
  output logic             out_last
);

  tok_t tok0, tok1, q_tok;
  logic push0, push1, room2, step;

  assign in_ready = room2;
  assign step     = in_valid && room2;

  lbl_core u_core (
    .clk, .rst_n, .step, .ch(in_ch), .line_end(in_line_end),
    .tok0, .tok1, .push0, .push1
  );

  lbl_outq u_outq (
    .clk, .rst_n, .push0, .push1, .tok0, .tok1, .room2,
    .q_valid(out_valid), .q_pop(out_ready), .q_tok
  );

  assign out_token_kind  = q_tok.kind;
  assign out_has_dot     = q_tok.has_dot;
  assign out_int_value   = q_tok.int_value;
  assign out_text_start  = q_tok.text_start;
  assign out_text_length = q_tok.text_length;
  assign out_token_total = q_tok.token_total;
  assign out_last        = q_tok.last;

endmodule
`default_nettype wire

// ===== tb/basic_line_lexer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basic_line_lexer_tb
// Feeds BASIC source lines to the lexer one character per request and checks
// every token against a behavioral lexer kept in step with the inputs.
// ----------------------------------------------------------------------------
module basic_line_lexer_tb;
  import lbl_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = 8'd0;
  logic        in_line_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_token_kind;
  logic        out_has_dot;
  logic [30:0] out_int_value;
  logic [7:0]  out_text_start;
  logic [7:0]  out_text_length;
  logic [7:0]  out_token_total;
  logic        out_last;

  basic_line_lexer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_ch(in_ch), .in_line_end(in_line_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_token_kind(out_token_kind), .out_has_dot(out_has_dot),
    .out_int_value(out_int_value), .out_text_start(out_text_start),
    .out_text_length(out_text_length), .out_token_total(out_token_total),
    .out_last(out_last)
  );

  always #6 clk = ~clk;

  // Behavioral lexer state.
  lbl_mode_t   mode;
  logic [7:0]  prefix [KW_CHARS];
  logic [7:0]  wlen, tstart, lpos, ntok;
  logic [30:0] accum;
  logic        dot_seen;

  tok_t   token_q[$];
  int     errors = 0;
  int     cycles = 0;

  localparam logic [7:0] OPS [11] = '{"+", "-", "*", "/", "^", "(", ")", ",", ";", ":", "="};
  localparam string KWS [KW_COUNT] = '{
    "PRINT", "LET", "IF", "THEN", "ELSE", "FOR", "TO", "STEP", "NEXT", "GOTO", "GOSUB",
    "RETURN", "INPUT", "REM", "CLS", "LOCATE", "COLOR", "END", "LIST", "RUN", "NEW",
    "SAVE", "LOAD", "SYSTEM"};

  function automatic logic [7:0] pos_inc(logic [7:0] v);
    return (v < 8'd255) ? v + 8'd1 : v;
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  task automatic push_token(logic [5:0] kind, logic isf, logic [30:0] ival,
                            logic [7:0] st, logic [7:0] len, logic [7:0] total);
    tok_t t;
    t = '0;
    t.kind = kind; t.has_dot = isf; t.int_value = ival;
    t.text_start = st; t.text_length = len; t.token_total = total;
    token_q.push_back(t);
    if (kind != K_END && ntok < 8'd255) ntok++;
  endtask

  task automatic push_word();
    logic [5:0] kind;
    string      kw;
    bit         same;
    kind = K_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      kw = KWS[k];
      if (kind == K_IDENT && wlen == kw.len()) begin
        same = 1'b1;
        for (int j = 0; j < kw.len(); j++) if (prefix[j] != kw[j]) same = 1'b0;
        if (same) kind = K_KEYWORD0 + 6'(k);
      end
    end
    push_token(kind, 1'b0, '0, tstart, wlen, 8'd0);
  endtask

  task automatic push_number();
    push_token(K_NUMBER, dot_seen, dot_seen ? 31'd0 : accum, tstart, wlen, 8'd0);
  endtask

  task automatic clear_line();
    mode = M_IDLE;
    for (int i = 0; i < KW_CHARS; i++) prefix[i] = 8'd0;
    wlen = 0; tstart = 0; lpos = 0; accum = 0; dot_seen = 0; ntok = 0;
  endtask

  task automatic begin_token(logic [7:0] c, logic [7:0] p);
    mode = M_IDLE;
    tstart = p;
    if (c == "?") push_token(K_KEYWORD0, 1'b0, '0, p, 8'd1, 8'd0);
    else if (c == "\"") begin
      mode = M_STRING; tstart = pos_inc(p); wlen = 0;
    end else if (digit_c(c)) begin
      mode = M_NUMBER; wlen = 1; dot_seen = 0; accum = 31'(c - "0");
    end else if (c == ".") mode = M_DOT;
    else if (alpha_c(c) || c == "_") begin
      for (int i = 0; i < KW_CHARS; i++) prefix[i] = 8'd0;
      prefix[0] = to_upper(c); wlen = 1; mode = M_WORD;
    end else if (c == "<") mode = M_LT;
    else if (c == ">") mode = M_GT;
    else begin
      for (int k = 0; k < 11; k++)
        if (c == OPS[k]) push_token(K_PLUS + 6'(k), 1'b0, '0, p, 8'd1, 8'd0);
    end
  endtask

  task automatic lex_char(logic [7:0] c, logic [7:0] p);
    logic [34:0] v;
    case (mode)
      M_STRING: begin
        if (c == "\"") begin
          push_token(K_STRING, 1'b0, '0, tstart, wlen, 8'd0); mode = M_IDLE;
        end else wlen = pos_inc(wlen);
      end
      M_NUMBER: begin
        if (digit_c(c)) begin
          v = accum * 35'd10 + 35'(c - "0");
          accum = (v > 35'(INT_CAP)) ? INT_CAP : v[30:0];
          wlen = pos_inc(wlen);
        end else if (c == ".") begin
          dot_seen = 1; wlen = pos_inc(wlen);
        end else begin
          push_number(); begin_token(c, p);
        end
      end
      M_WORD: begin
        if (alpha_c(c) || digit_c(c) || c == "_" || c == "$" || c == "%" || c == "!") begin
          if (wlen < KW_CHARS) prefix[wlen] = to_upper(c);
          wlen = pos_inc(wlen);
        end else begin
          push_word(); begin_token(c, p);
        end
      end
      M_DOT: begin
        if (digit_c(c)) begin
          mode = M_NUMBER; dot_seen = 1; accum = 0; wlen = 8'd2;
        end else begin_token(c, p);
      end
      M_LT: begin
        if (c == ">") begin
          push_token(K_NE, 1'b0, '0, tstart, 8'd2, 8'd0); mode = M_IDLE;
        end else if (c == "=") begin
          push_token(K_LE, 1'b0, '0, tstart, 8'd2, 8'd0); mode = M_IDLE;
        end else begin
          push_token(K_LT, 1'b0, '0, tstart, 8'd1, 8'd0); begin_token(c, p);
        end
      end
      M_GT: begin
        if (c == "=") begin
          push_token(K_GE, 1'b0, '0, tstart, 8'd2, 8'd0); mode = M_IDLE;
        end else begin
          push_token(K_GT, 1'b0, '0, tstart, 8'd1, 8'd0); begin_token(c, p);
        end
      end
      default: begin_token(c, p);
    endcase
  endtask

  // Updates the expected token queue for one accepted request.
  task automatic predict_tokens(logic [7:0] c, logic le);
    int n0;
    n0 = token_q.size();
    if (le) begin
      case (mode)
        M_STRING: push_token(K_STRING, 1'b0, '0, tstart, wlen, 8'd0);
        M_NUMBER: push_number();
        M_WORD:   push_word();
        M_LT:     push_token(K_LT, 1'b0, '0, tstart, 8'd1, 8'd0);
        M_GT:     push_token(K_GT, 1'b0, '0, tstart, 8'd1, 8'd0);
        default: ;
      endcase
      push_token(K_END, 1'b0, '0, 8'd0, 8'd0, ntok);
      clear_line();
    end else begin
      lex_char(c, lpos);
      lpos = pos_inc(lpos);
    end
    if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
  endtask

  // Valid stays high after an accept when the next request follows at once.
  task automatic send_char(logic [7:0] c, logic le);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_line_end <= le;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(c, le);
  endtask

  task automatic send_text(string s, bit end_line);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    if (end_line) send_char(8'd0, 1'b1);
  endtask

  // Output side: random stall, then compare each accepted token.
  initial begin
    int   stall;
    tok_t exp_t;
    forever begin
      stall = $urandom_range(0, 4);
      out_ready <= (stall == 0);
      @(posedge clk);
      if (stall != 0) stall--;
      if (rst_n && out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token kind %0d", $time, out_token_kind);
          errors++;
        end else begin
          exp_t = token_q.pop_front();
          if (out_token_kind !== exp_t.kind || out_has_dot !== exp_t.has_dot ||
              out_int_value !== exp_t.int_value || out_text_start !== exp_t.text_start ||
              out_text_length !== exp_t.text_length ||
              out_token_total !== exp_t.token_total || out_last !== exp_t.last) begin
            $display("%0t: expected kind %0d dot %0d int %0d st %0d len %0d tot %0d last %0d",
                     $time, exp_t.kind, exp_t.has_dot, exp_t.int_value, exp_t.text_start,
                     exp_t.text_length, exp_t.token_total, exp_t.last);
            $display("%0t: actual   kind %0d dot %0d int %0d st %0d len %0d tot %0d last %0d",
                     $time, out_token_kind, out_has_dot, out_int_value, out_text_start,
                     out_text_length, out_token_total, out_last);
            errors++;
          end
        end
      end
      while (stall > 0) begin
        out_ready <= 1'b0;
        @(posedge clk);
        stall--;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("basic_line_lexer: mismatch");
      $finish;
    end
  end

  task automatic test_keywords();
    send_text("print let if then else for to step next goto gosub return", 1'b1);
    send_text("INPUT REM CLS LOCATE COLOR END LIST RUN NEW SAVE LOAD SYSTEM", 1'b1);
    send_text("SYSTEMS prin Ab_9$%! x", 1'b1);
  endtask

  task automatic test_operators();
    send_text("?+-*/^(),;:=<><=>=<>", 1'b1);
    send_text("a<b>", 1'b1);
  endtask

  task automatic test_numbers();
    send_text("0 2147483647 99999999999 1.5 .5 . x .", 1'b1);
    send_text("3..4.", 1'b1);
  endtask

  task automatic test_strings_bytes();
    send_text("\"hi\" \"\"\"open", 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
  endtask

  // Long line saturates positions, lengths and the token count.
  task automatic test_long_line();
    logic [7:0] c;
    send_char("\"", 1'b0);
    repeat (300) begin
      c = 8'($urandom_range(32, 126));
      if (c == "\"") c = "a";
      send_char(c, 1'b0);
    end
    send_char(8'd0, 1'b1);
    repeat (280) send_char("+", 1'b0);
    send_char(8'd0, 1'b1);
  endtask

  function automatic string pick_piece();
    int sel;
    string s;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: s = KWS[$urandom_range(0, KW_COUNT - 1)];
      2: s = $sformatf("%0d", $urandom);
      3: s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
      4: s = "\"str ing\"";
      5: s = "<>";
      6: s = $urandom_range(0, 1) ? "<=" : ">=";
      7: s = "var_1$";
      default: s = " ";
    endcase
    return s;
  endfunction

  task automatic test_random();
    int   sent;
    string p;
    sent = 0;
    while (sent < 330) begin
      if ($urandom_range(0, 3) == 0) begin
        send_char(8'($urandom), $urandom_range(0, 15) == 0);
        sent++;
      end else begin
        p = pick_piece();
        send_text(p, 1'b0);
        sent += p.len();
        if ($urandom_range(0, 5) == 0) begin
          send_char(8'd0, 1'b1);
          sent++;
        end
      end
    end
    send_char(8'd0, 1'b1);
  endtask

  initial begin
    clear_line();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_keywords();
    test_operators();
    test_numbers();
    test_strings_bytes();
    wait_drained();
    test_long_line();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && token_q.size() == 0) begin
      $display("basic_line_lexer: match");
    end else begin
      $display("basic_line_lexer: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lbl_pkg.sv
rtl/lbl_core.sv
rtl/lbl_outq.sv
rtl/basic_line_lexer.sv
tb/basic_line_lexer_tb.sv
